>>> rtl/core/ps2a_pkg.sv
// Shared types, constants and the set-1 keymap for the scancode translator.
// No dependencies; imported by ps2a_xlat and the top level.
package ps2a_pkg;

  localparam int unsigned ScanW        = 8;
  localparam int unsigned CharW        = 8;
  localparam int unsigned FifoDepthDef = 256;

  localparam logic [6:0] LeftShift  = 7'h2A;
  localparam logic [6:0] RightShift = 7'h36;
  localparam logic [6:0] MapSize    = 7'd58;

  // Request codes on func_i
  localparam logic FuncScan = 1'b0;
  localparam logic FuncRead = 1'b1;

  // Outcome of translating one scancode byte
  typedef struct packed {
    logic             set_shift;
    logic             clr_shift;
    logic             char_vld;
    logic [CharW-1:0] char_val;
  } xlat_t;

  // Set-1 keymap, plain and shifted; zero means no character.
  function automatic logic [CharW-1:0] keymap(input logic [5:0] code, input logic shifted);
    logic [CharW-1:0] ch;
    ch = '0;
    case (code)
      6'd0:  ch = 8'h00;
      6'd1:  ch = 8'h1B;
      6'd2:  ch = shifted ? 8'h21 : 8'h31;
      6'd3:  ch = shifted ? 8'h40 : 8'h32;
      6'd4:  ch = shifted ? 8'h23 : 8'h33;
      6'd5:  ch = shifted ? 8'h24 : 8'h34;
      6'd6:  ch = shifted ? 8'h25 : 8'h35;
      6'd7:  ch = shifted ? 8'h5E : 8'h36;
      6'd8:  ch = shifted ? 8'h26 : 8'h37;
      6'd9:  ch = shifted ? 8'h2A : 8'h38;
      6'd10: ch = shifted ? 8'h28 : 8'h39;
      6'd11: ch = shifted ? 8'h29 : 8'h30;
      6'd12: ch = shifted ? 8'h5F : 8'h2D;
      6'd13: ch = shifted ? 8'h2B : 8'h3D;
      6'd14: ch = 8'h08;
      6'd15: ch = 8'h09;
      6'd16: ch = shifted ? 8'h51 : 8'h71;
      6'd17: ch = shifted ? 8'h57 : 8'h77;
      6'd18: ch = shifted ? 8'h45 : 8'h65;
      6'd19: ch = shifted ? 8'h52 : 8'h72;
      6'd20: ch = shifted ? 8'h54 : 8'h74;
      6'd21: ch = shifted ? 8'h59 : 8'h79;
      6'd22: ch = shifted ? 8'h55 : 8'h75;
      6'd23: ch = shifted ? 8'h49 : 8'h69;
      6'd24: ch = shifted ? 8'h4F : 8'h6F;
      6'd25: ch = shifted ? 8'h50 : 8'h70;
      6'd26: ch = shifted ? 8'h7B : 8'h5B;
      6'd27: ch = shifted ? 8'h7D : 8'h5D;
      6'd28: ch = 8'h0A;
      6'd29: ch = 8'h00;
      6'd30: ch = shifted ? 8'h41 : 8'h61;
      6'd31: ch = shifted ? 8'h53 : 8'h73;
      6'd32: ch = shifted ? 8'h44 : 8'h64;
      6'd33: ch = shifted ? 8'h46 : 8'h66;
      6'd34: ch = shifted ? 8'h47 : 8'h67;
      6'd35: ch = shifted ? 8'h48 : 8'h68;
      6'd36: ch = shifted ? 8'h4A : 8'h6A;
      6'd37: ch = shifted ? 8'h4B : 8'h6B;
      6'd38: ch = shifted ? 8'h4C : 8'h6C;
      6'd39: ch = shifted ? 8'h3A : 8'h3B;
      6'd40: ch = shifted ? 8'h22 : 8'h27;
      6'd41: ch = shifted ? 8'h7E : 8'h60;
      6'd42: ch = 8'h00;
      6'd43: ch = shifted ? 8'h7C : 8'h5C;
      6'd44: ch = shifted ? 8'h5A : 8'h7A;
      6'd45: ch = shifted ? 8'h58 : 8'h78;
      6'd46: ch = shifted ? 8'h43 : 8'h63;
      6'd47: ch = shifted ? 8'h56 : 8'h76;
      6'd48: ch = shifted ? 8'h42 : 8'h62;
      6'd49: ch = shifted ? 8'h4E : 8'h6E;
      6'd50: ch = shifted ? 8'h4D : 8'h6D;
      6'd51: ch = shifted ? 8'h3C : 8'h2C;
      6'd52: ch = shifted ? 8'h3E : 8'h2E;
      6'd53: ch = shifted ? 8'h3F : 8'h2F;
      6'd54: ch = 8'h00;
      6'd55: ch = 8'h2A;
      6'd56: ch = 8'h00;
      6'd57: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/ps2_scancode_to_ascii_fifo_top.sv
// Top level: set-1 keyboard translator feeding a character ring buffer.
// Depends on ps2a_pkg, ps2a_xlat and ps2a_ram.
//
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+-------------------------------
//  request  | start_i, busy_o, func_i, scan_byte_i   | start_i high while busy_o low
//  result   | done_o, ascii_char_o, empty_res_o      | done_o high, one cycle only
//
// A scancode transfer completes at the accepting edge: decode, keymap lookup and
// the ring write all happen there, and the next request may follow at once.
// For a read transfer the character RAM has a registered read port, so the
// result appears in the cycle after acceptance and busy_o is high during that
// cycle. Reset clears the shift flag and both ring pointers; the
// RAM is never cleared, since reads only reach entries already written. The
// receiver cannot stall: each result is shown for exactly one cycle.
module ps2_scancode_to_ascii_fifo_top
  import ps2a_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             func_i,
  input  logic [ScanW-1:0] scan_byte_i,
  output logic             done_o,
  output logic [CharW-1:0] ascii_char_o,
  output logic             empty_res_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);

  logic            shift_q, shift_d;
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW-1:0] wr_nxt, rd_nxt;
  logic            pend_q, pend_d;
  logic            empty_q, empty_d;

  logic             acc, acc_scan, acc_read;
  logic             ring_empty, ring_full;
  logic             ram_we, ram_re;
  logic [CharW-1:0] ram_rdata;
  xlat_t            xlat;

  // One request at a time; hold off new requests while a read is in flight.
  assign busy_o   = pend_q;
  assign acc      = start_i && !busy_o;
  assign acc_scan = acc && (func_i == FuncScan);
  assign acc_read = acc && (func_i == FuncRead);

  // Advance ring pointers with wrap at any depth, not only powers of two.
  assign wr_nxt = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
  assign rd_nxt = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;

  assign ring_empty = (wr_q == rd_q);
  assign ring_full  = (wr_nxt == rd_q);

  ps2a_xlat u_xlat (
    .scan_byte_i  (scan_byte_i),
    .shift_held_i (shift_q),
    .xlat_o       (xlat)
  );

  // Drop a translated character silently when the ring is full.
  assign ram_we = acc_scan && xlat.char_vld && !ring_full;
  assign ram_re = acc_read && !ring_empty;

  ps2a_ram #(
    .Width (CharW),
    .Depth (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (xlat.char_val),
    .re_i    (ram_re),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    shift_d = shift_q;
    if (acc_scan && xlat.set_shift) begin
      shift_d = 1'b1;
    end else if (acc_scan && xlat.clr_shift) begin
      shift_d = 1'b0;
    end
    wr_d    = ram_we ? wr_nxt : wr_q;
    rd_d    = ram_re ? rd_nxt : rd_q;
    pend_d  = acc_read;
    empty_d = acc_read ? ring_empty : empty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      wr_q    <= '0;
      rd_q    <= '0;
      pend_q  <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      shift_q <= shift_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      pend_q  <= pend_d;
      empty_q <= empty_d;
    end
  end

  // Present the read result in the cycle after acceptance, as a one-cycle strobe.
  assign done_o       = pend_q;
  assign empty_res_o  = empty_q;
  assign ascii_char_o = empty_q ? '0 : ram_rdata;

  // A result only ever follows an accepted read.
  a_done_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc_read))
    else $error("result strobe without a preceding read transfer");

  // A read of a non-empty ring must return a character.
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_read && !ring_empty) |=> (done_o && !empty_res_o))
    else $error("read of non-empty ring reported empty");

  // A write never lets the write pointer catch up with the read pointer.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (wr_q != rd_q))
    else $error("ring write overran the read pointer");

  // A scancode transfer never consumes a buffered character.
  a_scan_keeps_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_scan |=> (rd_q == $past(rd_q)))
    else $error("scancode transfer moved the read pointer");

endmodule

>>> rtl/core/ps2a_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ps2a_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ps2a_xlat.sv
// Set-1 scancode decoder: shift tracking requests and keymap lookup.
// Depends on ps2a_pkg.
module ps2a_xlat
  import ps2a_pkg::*;
(
  input  logic [ScanW-1:0] scan_byte_i,
  input  logic             shift_held_i,
  output xlat_t            xlat_o
);

  logic       release_key;
  logic [6:0] key;
  logic       is_shift;

  assign release_key = scan_byte_i[ScanW-1];
  assign key         = scan_byte_i[6:0];
  assign is_shift    = (key == LeftShift) || (key == RightShift);

  always_comb begin
    xlat_o = '0;
    if (release_key) begin
      xlat_o.clr_shift = is_shift;
    end else if (is_shift) begin
      xlat_o.set_shift = 1'b1;
    end else if (key < MapSize) begin
      xlat_o.char_val = keymap(key[5:0], shift_held_i);
      xlat_o.char_vld = (xlat_o.char_val != '0);
    end
  end

endmodule
